// ===== hw/rtl/ring_byte_buffer_peek_consume_assert.svh =====
// Assertion macros for the ring byte buffer, clocked on clk and disabled by rst.
`ifndef RING_BYTE_BUFFER_PEEK_CONSUME_ASSERT_SVH
`define RING_BYTE_BUFFER_PEEK_CONSUME_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring byte buffer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring byte buffer assertion failed");

`endif

// ===== hw/rtl/rbb_pkg.sv =====
// Shared constants and codes of the ring byte buffer.
package rbb_pkg;

  localparam int DEPTH     = 256;
  localparam int MAX_PEEK  = 64;
  localparam int CAP_LIMIT = (DEPTH < 256) ? DEPTH : 256;

  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int AMT_W  = 8;
  localparam int ST_W   = 2;
  localparam int CAP_W  = 9;
  localparam int PTR_W  = $clog2(CAP_LIMIT);
  localparam int RAM_AW = $clog2(DEPTH);
  localparam int WIDE_W = AMT_W + 2;
  localparam int LEFT_W = $clog2(MAX_PEEK + 1);

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NODATA  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [ST_W-1:0] ST_TOOLONG = 2'd3;

  localparam logic [CAP_W-1:0] CAP_MIN   = 9'd2;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

// ===== hw/rtl/rbb_ifs.sv =====
// Handshake channel interfaces of the ring byte buffer: items, results, configuration.
interface rbb_item_if;
  logic                        valid;
  logic                        ready;
  logic [rbb_pkg::KIND_W-1:0]  kind;
  logic [rbb_pkg::BYTE_W-1:0]  write_byte;
  logic                        first_of_block;
  logic [rbb_pkg::AMT_W-1:0]   amount;
  logic [rbb_pkg::AMT_W-1:0]   offset;

  modport source (output valid, kind, write_byte, first_of_block, amount, offset,
                  input ready);
  modport sink   (input valid, kind, write_byte, first_of_block, amount, offset,
                  output ready);
endinterface

interface rbb_result_if;
  logic                        valid;
  logic                        ready;
  logic [rbb_pkg::ST_W-1:0]    status;
  logic [rbb_pkg::BYTE_W-1:0]  read_byte;
  logic                        last;
  logic [rbb_pkg::AMT_W-1:0]   data_length;
  logic [rbb_pkg::AMT_W-1:0]   spare_length;

  modport source (output valid, status, read_byte, last, data_length, spare_length,
                  input ready);
  modport sink   (input valid, status, read_byte, last, data_length, spare_length,
                  output ready);
endinterface

interface rbb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rbb_pkg::CAP_W-1:0]   capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== hw/rtl/rbb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ring_byte_buffer_peek_consume.sv =====
// Ring byte buffer with all-or-nothing write blocks, peeks and head advances.
//
// The buffer keeps one slot free, so with an effective capacity C (the
// capacity register clamped to 2..256) it holds at most C-1 bytes. A write,
// an advance, a rejected or empty peek and an unused kind each give one
// result; such items can follow each other every cycle while the receiver is
// ready, since a result register parts the input from the output side. An
// accepted peek of N bytes keeps the input closed until its last byte is
// loaded: the start address is latched at the transfer itself, the issue
// state sends the first RAM read, then one byte a cycle follows, paced by
// the RAM's single registered read port and by the result register whenever
// the receiver stalls. The storage is not cleared after reset; peeks reach
// only bytes that were written. A transfer on the configuration channel is
// taken in any cycle, empties the ring and ends any open write block.
module ring_byte_buffer_peek_consume (
  input logic         clk,
  input logic         rst,
  rbb_item_if.sink    item,
  rbb_result_if.source result,
  rbb_cfg_if.sink     cfg
);

  import rbb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DATA
  } state_t;

  state_t state;

  // Ring control state; the bytes themselves live in the RAM.
  logic [CAP_W-1:0]  cap;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  count;
  logic              block_accepting;
  logic [AMT_W-1:0]  block_remaining;

  // Peek run bookkeeping.
  logic [PTR_W-1:0]  peek_idx;
  logic [LEFT_W-1:0] peek_left;

  // Result register.
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic [AMT_W-1:0]  out_dlen;
  logic [AMT_W-1:0]  out_slen;

  // Decoded effect of the item offered this cycle.
  logic [ST_W-1:0]   status_next;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;
  logic [PTR_W-1:0]  count_next;
  logic              accepting_next;
  logic [AMT_W-1:0]  remaining_next;
  logic              start_run;
  logic [PTR_W-1:0]  peek_start;
  logic              store;

  logic              item_fire;
  logic              cfg_fire;
  logic              slot_free;
  logic              run_more;
  logic              out_load;
  logic [PTR_W-1:0]  peek_idx_inc;
  logic [CAP_W-1:0]  cap_clamped;

  logic [WIDE_W-1:0] w_cap;
  logic [WIDE_W-1:0] w_count;
  logic [WIDE_W-1:0] w_amount;
  logic [WIDE_W-1:0] w_spare;

  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Adds two ring positions and folds the sum back into 0..C-1. Callers make
  // sure the sum stays below twice the capacity.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [WIDE_W-1:0] a,
                                                input logic [WIDE_W-1:0] b,
                                                input logic [WIDE_W-1:0] c);
    logic [WIDE_W-1:0] s;
    s = a + b;
    if (s >= c) begin
      s = s - c;
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [AMT_W-1:0] spare_of(input logic [WIDE_W-1:0] c,
                                                input logic [PTR_W-1:0] n);
    return AMT_W'(c - WIDE_W'(1) - WIDE_W'(n));
  endfunction

  assign slot_free    = !out_valid || result.ready;
  assign item.ready   = (state == S_IDLE) && slot_free;
  assign item_fire    = item.valid && item.ready;
  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid;

  assign w_cap        = WIDE_W'(cap);
  assign w_count      = WIDE_W'(count);
  assign w_amount     = WIDE_W'(item.amount);
  assign w_spare      = w_cap - WIDE_W'(1) - w_count;
  assign peek_idx_inc = wrap_add(WIDE_W'(peek_idx), WIDE_W'(1), w_cap);

  // The run continues past this byte only while more bytes remain.
  assign run_more     = (peek_left != LEFT_W'(1));

  // The result register takes a new entry for every single-result item and
  // for every byte of a run that finds the register free.
  assign out_load     = (item_fire && !start_run) || ((state == S_DATA) && slot_free);

  always_comb begin
    cap_clamped = cfg.capacity_in_use;
    if (cap_clamped < CAP_MIN) begin
      cap_clamped = CAP_MIN;
    end
    if (cap_clamped > CAP_W'(CAP_LIMIT)) begin
      cap_clamped = CAP_W'(CAP_LIMIT);
    end
  end

  always_comb begin
    status_next    = ST_OK;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    accepting_next = block_accepting;
    remaining_next = block_remaining;
    start_run      = 1'b0;
    store          = 1'b0;
    peek_start     = wrap_add(WIDE_W'(head), WIDE_W'(item.offset), w_cap);
    case (item.kind)
      KIND_WRITE: begin
        if (item.first_of_block) begin
          // The first byte reserves the whole block or rejects it outright.
          if (w_spare >= w_amount) begin
            accepting_next = (item.amount != '0);
            remaining_next = item.amount;
          end else begin
            accepting_next = 1'b0;
            remaining_next = '0;
            status_next    = ST_NOSPACE;
          end
        end else if (!block_accepting) begin
          status_next = ST_NOSPACE;
        end
        if (status_next == ST_OK && accepting_next && remaining_next != '0) begin
          store          = 1'b1;
          tail_next      = wrap_add(WIDE_W'(tail), WIDE_W'(1), w_cap);
          count_next     = count + PTR_W'(1);
          remaining_next = remaining_next - AMT_W'(1);
          if (remaining_next == '0) begin
            accepting_next = 1'b0;
          end
        end
      end
      KIND_PEEK: begin
        if (w_count < w_amount + WIDE_W'(item.offset)) begin
          status_next = ST_NODATA;
        end else if (w_amount > WIDE_W'(MAX_PEEK)) begin
          status_next = ST_TOOLONG;
        end else if (item.amount != '0) begin
          start_run = 1'b1;
        end
      end
      KIND_ADVANCE: begin
        if (w_amount > w_count) begin
          status_next = ST_NODATA;
        end else begin
          head_next  = wrap_add(WIDE_W'(head), w_amount, w_cap);
          count_next = count - PTR_W'(item.amount);
        end
      end
      default: begin
      end
    endcase
  end

  // The first read of a run is issued from its own state; later reads go out
  // as each byte moves into the result register, so the RAM output holds
  // while the receiver stalls. Writes happen only at item transfers, which
  // never coincide with a run, so reads always see written data.
  assign ram_re    = (state == S_ISSUE) || ((state == S_DATA) && slot_free && run_more);
  assign ram_raddr = RAM_AW'((state == S_ISSUE) ? peek_idx : peek_idx_inc);

  rbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_storage (
    .clk   (clk),
    .we    (item_fire && store),
    .waddr (RAM_AW'(tail)),
    .wdata (item.write_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cap             <= CAP_RESET;
      head            <= '0;
      tail            <= '0;
      count           <= '0;
      block_accepting <= 1'b0;
      block_remaining <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_fire) begin
            if (start_run) begin
              state     <= S_ISSUE;
              peek_idx  <= peek_start;
              peek_left <= LEFT_W'(item.amount);
            end else begin
              out_status <= status_next;
              out_byte   <= '0;
              out_last   <= 1'b1;
              out_dlen   <= AMT_W'(count_next);
              out_slen   <= spare_of(w_cap, count_next);
            end
          end
        end
        S_ISSUE: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (slot_free) begin
            out_status <= ST_OK;
            out_byte   <= ram_rdata;
            out_last   <= !run_more;
            out_dlen   <= AMT_W'(count);
            out_slen   <= spare_of(w_cap, count);
            if (run_more) begin
              peek_idx  <= peek_idx_inc;
              peek_left <= peek_left - LEFT_W'(1);
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A capacity change empties the ring and closes any open block; it
      // takes priority over the effect of an item taken in the same cycle.
      if (cfg_fire) begin
        cap             <= cap_clamped;
        head            <= '0;
        tail            <= '0;
        count           <= '0;
        block_accepting <= 1'b0;
        block_remaining <= '0;
      end else if (item_fire) begin
        head            <= head_next;
        tail            <= tail_next;
        count           <= count_next;
        block_accepting <= accepting_next;
        block_remaining <= remaining_next;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.read_byte    = out_byte;
  assign result.last         = out_last;
  assign result.data_length  = out_dlen;
  assign result.spare_length = out_slen;

`include "ring_byte_buffer_peek_consume_assert.svh"

  // The ring never holds more than C-1 bytes.
  `RBB_ASSERT_IMPL(a_count_bound, 1'b1, WIDE_W'(count) < WIDE_W'(cap))
  // An open block always has bytes left to take, and a spent one is closed.
  `RBB_ASSERT_IMPL(a_block_consistent, block_accepting, block_remaining != '0)
  // No item is taken while a peek run is in flight.
  `RBB_ASSERT_IMPL(a_run_blocks_input, state != S_IDLE, !item.ready)
  // A byte that is not the last of its run is followed by more of the run.
  `RBB_ASSERT_NEXT(a_run_continues, state == S_DATA && slot_free && run_more,
                   state == S_DATA)

endmodule

// ===== tb/tb_ring_byte_buffer_peek_consume.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ring byte buffer: directed and random traffic.
module tb_ring_byte_buffer_peek_consume;
  import rbb_pkg::*;

  // The fourth kind code has no function in the block; it must still answer with one
  // plain status result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned CLK_PERIOD       = 20;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned MISMATCH_REPORTS = 10;
  // The slowest correct run (every peek at full length, every result waiting out the
  // longest stall, every item behind the longest sender gap) stays far below this.
  localparam int unsigned CYCLE_LIMIT      = 1_500_000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] write_byte;
    logic              first_of_block;
    logic [AMT_W-1:0]  amount;
    logic [AMT_W-1:0]  offset;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
    logic [AMT_W-1:0]  data_length;
    logic [AMT_W-1:0]  spare_length;
  } result_t;

  // Mirror of the ring. Every accepted item is played against the mirror's own copy of
  // the storage, the pointers and the open write block, and the results it should
  // cause are queued in order. Each result transfer from the block is then matched
  // against the oldest entry of that queue.
  class byte_ring_scoreboard;
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       cap;
    int unsigned       block_left;
    bit                block_open;
    result_t           expected_results [$];
    int unsigned       mismatches;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      cap        = CAP_RESET;
      head       = 0;
      tail       = 0;
      block_left = 0;
      block_open = 1'b0;
      mismatches = 0;
    endfunction

    // A capacity write clamps to the legal range and also empties the ring.
    function void set_capacity(logic [CAP_W-1:0] value);
      int unsigned v;
      v = value;
      if (v < CAP_MIN) v = CAP_MIN;
      if (v > CAP_LIMIT) v = CAP_LIMIT;
      cap        = v;
      head       = 0;
      tail       = 0;
      block_left = 0;
      block_open = 1'b0;
    endfunction

    function int unsigned held();
      return (tail >= head) ? tail - head : tail + cap - head;
    endfunction

    function int unsigned spare();
      return cap - 1 - held();
    endfunction

    // Counts in a result always reflect the ring after the item has taken effect.
    function void queue_result(logic [ST_W-1:0] st, logic [BYTE_W-1:0] rd, logic fin);
      result_t     r;
      int unsigned d;
      int unsigned s;
      d = held();
      s = spare();
      r.status       = st;
      r.read_byte    = rd;
      r.last         = fin;
      r.data_length  = d[AMT_W-1:0];
      r.spare_length = s[AMT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void note_item(item_t it);
      int unsigned     held_now;
      int unsigned     reach;
      int unsigned     idx;
      logic [ST_W-1:0] st;
      held_now = held();
      reach    = int'(it.amount) + int'(it.offset);
      case (it.kind)
        KIND_WRITE: begin
          st = ST_OK;
          // A first byte opens a new block, abandoning any unfinished one, but only
          // if the whole declared length fits in the free space.
          if (it.first_of_block) begin
            if (spare() >= it.amount) begin
              block_open = (it.amount != 0);
              block_left = it.amount;
            end else begin
              block_open = 1'b0;
              block_left = 0;
              st         = ST_NOSPACE;
            end
          end else if (!block_open) begin
            st = ST_NOSPACE;
          end
          if (st == ST_OK && block_open && block_left > 0) begin
            ring_mem[tail] = it.write_byte;
            tail = (tail + 1 == cap) ? 0 : tail + 1;
            block_left--;
            if (block_left == 0) block_open = 1'b0;
          end
          queue_result(st, '0, 1'b1);
        end
        KIND_PEEK: begin
          // Missing data is checked before the length limit.
          if (held_now < reach) begin
            queue_result(ST_NODATA, '0, 1'b1);
          end else if (it.amount > MAX_PEEK) begin
            queue_result(ST_TOOLONG, '0, 1'b1);
          end else if (it.amount == 0) begin
            queue_result(ST_OK, '0, 1'b1);
          end else begin
            idx = head + it.offset;
            if (idx >= cap) idx -= cap;
            for (int j = 1; j <= int'(it.amount); j++) begin
              queue_result(ST_OK, ring_mem[idx], j == int'(it.amount));
              idx = (idx + 1 == cap) ? 0 : idx + 1;
            end
          end
        end
        KIND_ADVANCE: begin
          if (it.amount > held_now) begin
            queue_result(ST_NODATA, '0, 1'b1);
          end else begin
            head += it.amount;
            if (head >= cap) head -= cap;
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        default: begin
          queue_result(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("status %0d byte %02h last %0d data %0d spare %0d",
                       r.status, r.read_byte, r.last, r.data_length, r.spare_length);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MISMATCH_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        flag({"result with nothing expected: ", show(got)});
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.read_byte !== want.read_byte ||
          got.last !== want.last || got.data_length !== want.data_length ||
          got.spare_length !== want.spare_length) begin
        flag({"expected ", show(want), ", got ", show(got)});
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  bit          allow_idle  = 1'b1;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;

  rbb_item_if   item_bus ();
  rbb_result_if result_bus ();
  rbb_cfg_if    cfg_bus ();

  byte_ring_scoreboard ring_sb = new();

  ring_byte_buffer_peek_consume u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Every transfer on the result channel is checked at the rising edge that takes it.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      ring_sb.check_result('{result_bus.status, result_bus.read_byte, result_bus.last,
                             result_bus.data_length, result_bus.spare_length});
    end
  end

  // The receiver alternates between bursts of stall and bursts of readiness. Once idling
  // is switched off for the last part of the run it simply stays ready.
  initial begin : result_pacing
    int unsigned span;
    forever begin
      if (allow_idle && $urandom_range(0, 2) == 0) begin
        result_bus.ready <= 1'b0;
        span = $urandom_range(1, 13);
      end else begin
        result_bus.ready <= 1'b1;
        span = $urandom_range(1, 20);
      end
      repeat (span) @(negedge clk);
    end
  end

  // A hung handshake or a lost result ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // One item is presented at a falling edge and held until its transfer. The valid line
  // is left high afterward, so back-to-back items never see it dropped; a random gap
  // lowers it at one falling edge and raises it again at a later one.
  task automatic send_item(input item_t it);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.kind           <= it.kind;
    item_bus.write_byte     <= it.write_byte;
    item_bus.first_of_block <= it.first_of_block;
    item_bus.amount         <= it.amount;
    item_bus.offset         <= it.offset;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    ring_sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind, input int unsigned wbyte,
                             input int unsigned first, input int unsigned amt,
                             input int unsigned off);
    item_t it;
    it.kind           = kind;
    it.write_byte     = wbyte[BYTE_W-1:0];
    it.first_of_block = first[0];
    it.amount         = amt[AMT_W-1:0];
    it.offset         = off[AMT_W-1:0];
    send_item(it);
  endtask

  // A write block: the first byte carries the declared length, the rest carry random
  // junk in the fields that a write ignores. Sending fewer bytes than declared leaves
  // the block open for the next first byte to abandon.
  task automatic send_block(input int unsigned declared, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_fields(KIND_WRITE, $urandom_range(0, 255), (i == 0) ? 1 : 0,
                  (i == 0) ? declared : $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // The sender stops and waits for every expected result to come back.
  task automatic wait_for_drain();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (ring_sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // The capacity register is written only with the ring quiet. Every item causes at
  // least one result, so an empty queue means nothing is left in flight; spare cycles
  // are still waited out before the write.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_for_drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid           <= 1'b1;
    cfg_bus.capacity_in_use <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    ring_sb.set_capacity(value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random traffic built mostly from well-formed operations sized against the mirror's
  // current fill level, so that peeks and advances land on held data and blocks fit,
  // plus a share of oversize blocks, overreaching peeks and advances, and pure noise.
  task automatic random_traffic(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned held_now;
    int unsigned room;
    int unsigned len;
    int unsigned burst;
    int unsigned off;
    int unsigned amt;
    int unsigned noise_kind;
    target = items_sent + count;
    while (items_sent < target) begin
      pick     = $urandom_range(0, 99);
      held_now = ring_sb.held();
      room     = ring_sb.spare();
      if (pick < 40) begin
        if (room == 0 || $urandom_range(0, 7) == 0) begin
          // Declared length beyond the free space unless the 8-bit field caps it, followed
          // by up to two stray bytes that a rejected block must drop.
          len = room + $urandom_range(1, 8);
          if (len > 255) len = 255;
          burst = $urandom_range(1, 3);
        end else if ($urandom_range(0, 15) == 0) begin
          len   = 0;
          burst = $urandom_range(1, 2);
        end else begin
          len   = $urandom_range(1, (room < 24) ? room : 24);
          burst = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
        end
        send_block(len, burst);
      end else if (pick < 65) begin
        off = $urandom_range(0, held_now);
        if ($urandom_range(0, 9) == 0) begin
          amt = held_now - off + $urandom_range(1, 4);
        end else begin
          amt = $urandom_range(0, (held_now - off < 72) ? held_now - off : 72);
        end
        if (amt > 255) amt = 255;
        send_fields(KIND_PEEK, $urandom_range(0, 255), $urandom_range(0, 1), amt, off);
      end else if (pick < 85) begin
        if ($urandom_range(0, 7) == 0) begin
          amt = held_now + $urandom_range(1, 4);
          if (amt > 255) amt = 255;
        end else begin
          amt = $urandom_range(0, held_now);
        end
        send_fields(KIND_ADVANCE, $urandom_range(0, 255), $urandom_range(0, 1), amt,
                    $urandom_range(0, 255));
      end else begin
        noise_kind = $urandom_range(0, 3);
        send_fields(noise_kind[KIND_W-1:0], $urandom_range(0, 255), $urandom_range(0, 1),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin : stimulus
    item_bus.valid          = 1'b0;
    item_bus.kind           = KIND_WRITE;
    item_bus.write_byte     = '0;
    item_bus.first_of_block = 1'b0;
    item_bus.amount         = '0;
    item_bus.offset         = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.capacity_in_use = CAP_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset capacity. First the empty ring: the unused kind, a
    // stray byte with no block open, a zero-length block (which stores nothing, so the
    // byte after it is stray too), an empty peek, and reads and advances with no data.
    send_fields(KIND_UNUSED, 8'hFF, 1, 8'hFF, 8'hFF);
    send_fields(KIND_WRITE, 8'hAA, 0, 0, 0);
    send_fields(KIND_WRITE, 8'h11, 1, 0, 0);
    send_fields(KIND_WRITE, 8'h22, 0, 3, 0);
    send_fields(KIND_PEEK, 0, 0, 0, 0);
    send_fields(KIND_PEEK, 0, 0, 1, 0);
    send_fields(KIND_ADVANCE, 0, 0, 1, 0);
    send_fields(KIND_ADVANCE, 0, 0, 0, 0);
    // A block of four cut short after three bytes by a new block of two, which
    // completes; a byte after the finished block is dropped.
    send_fields(KIND_WRITE, 8'h00, 1, 4, 0);
    send_fields(KIND_WRITE, 8'hFF, 0, 0, 0);
    send_fields(KIND_WRITE, 8'h5A, 0, 0, 0);
    send_fields(KIND_WRITE, 8'hC3, 1, 2, 0);
    send_fields(KIND_WRITE, 8'h3C, 0, 0, 0);
    send_fields(KIND_WRITE, 8'h77, 0, 0, 0);
    // A block longer than the free space is rejected whole, and so is its next byte.
    send_fields(KIND_WRITE, 8'h80, 1, 255, 0);
    send_fields(KIND_WRITE, 8'h01, 0, 0, 0);
    // Peeks over the held bytes, then peeks that reach past them at the field extremes.
    send_fields(KIND_PEEK, 0, 0, 5, 0);
    send_fields(KIND_PEEK, 0, 0, 2, 3);
    send_fields(KIND_PEEK, 0, 0, 0, 255);
    send_fields(KIND_PEEK, 8'hFF, 1, 255, 255);
    send_fields(KIND_ADVANCE, 0, 0, 255, 0);
    send_fields(KIND_ADVANCE, 0, 0, 2, 0);
    send_fields(KIND_PEEK, 0, 0, 3, 0);
    send_fields(KIND_PEEK, 8'hFF, 1, 1, 2);

    // Full-size ring, filled deep enough for the longest peek and for one just over
    // the limit that still has the data behind it.
    write_capacity(9'd256);
    send_block(100, 100);
    send_fields(KIND_PEEK, 0, 0, MAX_PEEK, 0);
    send_fields(KIND_PEEK, 0, 0, MAX_PEEK + 1, 10);
    send_fields(KIND_PEEK, 0, 0, 200, 0);
    random_traffic(40);

    // Zero clamps up to the smallest ring, which holds a single byte.
    write_capacity(9'd0);
    random_traffic(30);

    write_capacity(9'd3);
    random_traffic(30);

    // The all-ones value clamps down to the largest ring.
    write_capacity(9'h1FF);
    random_traffic(40);

    write_capacity(9'd17);
    random_traffic(40);

    write_capacity(CAP_MIN);
    random_traffic(20);

    // Last stretch runs with no idling on either side.
    allow_idle = 1'b0;
    write_capacity(9'd100);
    random_traffic(30);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ring_sb.mismatches == 0 && ring_sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
